[src/bct_pkg.sv]
// Shared types and constants for the Bezier curve tessellator.
// No dependencies; every other file of the block imports this package.
package bct_pkg;

  // Store depth default and field widths
  localparam int unsigned MAX_CONTROL_POINTS_DEF = 16;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned T_FRAC  = 16;
  localparam int unsigned T_W     = T_FRAC + 1;
  localparam int unsigned NUM_W   = STEP_W + T_FRAC;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

  // Register reset value and step floor
  localparam logic [STEP_W-1:0] STEP_COUNT_RST = STEP_W'(16);
  localparam logic [STEP_W-1:0] MIN_STEPS      = STEP_W'(2);

  // Lane 0 left, lane 1 up, lane 2 forward
  typedef logic [2:0][COORD_W-1:0] point_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_START,
    ST_T_WAIT,
    ST_ROW,
    ST_RD_B,
    ST_SUB,
    ST_MUL,
    ST_ADD,
    ST_OUT_RD,
    ST_OUT
  } bct_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic store_we;
    logic work_we;
    logic rd_en;
    logic src_stored;
    logic load_a;
    logic do_sub;
    logic do_mul;
    logic capture;
    logic div_start;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

[src/bct_tgen.sv]
// Parameter generator: t = floor((i*65536 + steps/2) / steps), restoring
// division one quotient bit per cycle. Depends on bct_pkg.
module bct_tgen import bct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [STEP_W-1:0] vert_idx_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic              done_o,
  output logic [T_W-1:0]    t_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     num_q;
  logic [STEP_W-1:0]    rem_q;
  logic [NUM_W-1:0]     num_init;
  logic [STEP_W:0]      trial;
  logic                 ge;
  logic [STEP_W-1:0]    rem_d;

  // Numerator with half the divisor added for rounding
  assign num_init = {vert_idx_i, {T_FRAC{1'b0}}} + NUM_W'(steps_i >> 1);

  // One restoring step: bring down a bit, subtract where it fits
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, steps_i});
  assign rem_d = ge ? STEP_W'(trial - {1'b0, steps_i}) : trial[STEP_W-1:0];

  // Control: count the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(NUM_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Shift quotient bits in as numerator bits go out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_init;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = !busy_q;
  assign t_o    = num_q[T_W-1:0];

endmodule

[src/bct_datapath.sv]
// Datapath: control point store, interpolation scratch store, shared
// three-lane lerp unit and parameter divider. Depends on bct_pkg, bct_tgen.
module bct_datapath import bct_pkg::*; #(
  parameter int unsigned MAX_CONTROL_POINTS = MAX_CONTROL_POINTS_DEF,
  localparam int unsigned IDX_W = (MAX_CONTROL_POINTS > 1) ? $clog2(MAX_CONTROL_POINTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  input  logic [STEP_W-1:0]  vert_idx_i,
  input  logic [STEP_W-1:0]  steps_i,
  input  point_t             point_i,
  output dp_status_t         status_o,
  output point_t             vertex_o
);

  point_t store_mem [MAX_CONTROL_POINTS];
  point_t work_mem  [MAX_CONTROL_POINTS];
  point_t store_rd_q;
  point_t work_rd_q;
  logic   src_q;
  point_t b_pt;
  point_t res_pt;
  point_t vtx_q;

  logic signed [COORD_W-1:0] a_q    [3];
  logic signed [COORD_W:0]   diff_q [3];
  logic signed [COORD_W:0]   diff_d [3];
  logic signed [50:0]        prod_q [3];
  logic signed [50:0]        prod_d [3];
  logic signed [50:0]        rnd    [3];
  logic signed [T_W:0]       t_s;
  logic [T_W-1:0]            t;
  logic                      div_done;

  // Parameter value for the current vertex
  bct_tgen u_tgen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .vert_idx_i (vert_idx_i),
    .steps_i    (steps_i),
    .done_o     (div_done),
    .t_o        (t)
  );

  assign t_s = $signed({1'b0, t});

  // Write ports of the two stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we) begin
      store_mem[wr_addr_i] <= point_i;
    end
    if (cmd_i.work_we) begin
      work_mem[wr_addr_i] <= res_pt;
    end
  end

  // Registered read of both stores, source chosen after the register
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      store_rd_q <= store_mem[rd_addr_i];
      work_rd_q  <= work_mem[rd_addr_i];
      src_q      <= cmd_i.src_stored;
    end
  end

  assign b_pt = src_q ? store_rd_q : work_rd_q;

  // Lerp per lane: a + floor(((b - a) * t + 32768) / 65536)
  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign diff_d[l] = $signed({b_pt[l][COORD_W-1], b_pt[l]}) -
                       $signed({a_q[l][COORD_W-1], a_q[l]});
    assign prod_d[l] = diff_q[l] * t_s;
    assign rnd[l]    = prod_q[l] + 51'sd32768;
    assign res_pt[l] = a_q[l] + rnd[l][47:16];

    always_ff @(posedge clk_i) begin
      if (cmd_i.load_a || cmd_i.work_we) begin
        a_q[l] <= b_pt[l];
      end
      if (cmd_i.do_sub) begin
        diff_q[l] <= diff_d[l];
      end
      if (cmd_i.do_mul) begin
        prod_q[l] <= prod_d[l];
      end
    end
  end

  // Hold the finished vertex for the output strobe
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vtx_q <= b_pt;
    end
  end

  assign vertex_o          = vtx_q;
  assign status_o.div_done = div_done;

endmodule

[src/bct_ctrl.sv]
// Controller: step count register, point count, vertex, row and column
// counters and the sequencer state machine. Depends on bct_pkg.
module bct_ctrl import bct_pkg::*; #(
  parameter int unsigned MAX_CONTROL_POINTS = MAX_CONTROL_POINTS_DEF,
  localparam int unsigned IDX_W = (MAX_CONTROL_POINTS > 1) ? $clog2(MAX_CONTROL_POINTS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_CONTROL_POINTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_point_i,
  input  logic              cfg_valid_i,
  input  logic [STEP_W-1:0] cfg_data_i,
  input  dp_status_t        status_i,
  output dp_cmd_t           cmd_o,
  output logic [IDX_W-1:0]  wr_addr_o,
  output logic [IDX_W-1:0]  rd_addr_o,
  output logic [STEP_W-1:0] vert_idx_o,
  output logic [STEP_W-1:0] steps_o,
  output logic              busy_o,
  output logic              valid_o,
  output logic              last_o
);

  bct_state_e        state_q, state_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [CNT_W-1:0]  w_q, w_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [STEP_W-1:0] i_q, i_d;
  logic [STEP_W-1:0] step_count_q, step_count_d;
  logic              valid_q, valid_d;
  logic              last_q, last_d;
  logic [STEP_W-1:0] steps;
  logic              full;
  logic              first_row;
  logic              row_end;

  assign steps     = (step_count_q < MIN_STEPS) ? MIN_STEPS : step_count_q;
  assign full      = (held_q == CNT_W'(MAX_CONTROL_POINTS));
  assign first_row = (w_q == held_q);
  assign row_end   = ((CNT_W'(k_q) + 1'b1) == (w_q - 1'b1));

  // State and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      held_q       <= '0;
      w_q          <= '0;
      k_q          <= '0;
      i_q          <= '0;
      step_count_q <= STEP_COUNT_RST;
      valid_q      <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_q       <= held_d;
      w_q          <= w_d;
      k_q          <= k_d;
      i_q          <= i_d;
      step_count_q <= step_count_d;
      valid_q      <= valid_d;
      last_q       <= last_d;
    end
  end

  // Next state, counters and datapath commands
  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    w_d          = w_q;
    k_d          = k_q;
    i_d          = i_q;
    step_count_d = cfg_valid_i ? cfg_data_i : step_count_q;
    valid_d      = 1'b0;
    last_d       = 1'b0;
    cmd_o        = '0;
    wr_addr_o    = k_q;
    rd_addr_o    = '0;

    unique case (state_q)
      ST_IDLE: begin
        // Store the item unless the store is full; evaluate on the last one
        wr_addr_o = held_q[IDX_W-1:0];
        if (start_i) begin
          if (!full) begin
            cmd_o.store_we = 1'b1;
            held_d         = held_q + 1'b1;
          end
          if (last_point_i) begin
            i_d     = '0;
            state_d = ST_T_START;
          end
        end
      end
      ST_T_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_T_WAIT;
      end
      ST_T_WAIT: begin
        if (status_i.div_done) begin
          w_d     = held_q;
          state_d = (held_q == CNT_W'(1)) ? ST_OUT_RD : ST_ROW;
        end
      end
      ST_ROW: begin
        // Fetch the first point of the row
        cmd_o.rd_en      = 1'b1;
        cmd_o.src_stored = first_row;
        k_d              = '0;
        state_d          = ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.rd_en      = 1'b1;
        cmd_o.src_stored = first_row;
        cmd_o.load_a     = (k_q == '0);
        rd_addr_o        = k_q + 1'b1;
        state_d          = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.do_sub = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.do_mul = 1'b1;
        state_d      = ST_ADD;
      end
      ST_ADD: begin
        // Write back and advance along the row, or shrink the row
        cmd_o.work_we = 1'b1;
        if (row_end) begin
          w_d     = w_q - 1'b1;
          state_d = (w_q == CNT_W'(2)) ? ST_OUT_RD : ST_ROW;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_RD_B;
        end
      end
      ST_OUT_RD: begin
        cmd_o.rd_en      = 1'b1;
        cmd_o.src_stored = first_row;
        state_d          = ST_OUT;
      end
      ST_OUT: begin
        // Present the vertex; finish the curve at t = 1
        cmd_o.capture = 1'b1;
        valid_d       = 1'b1;
        last_d        = (i_q == steps);
        if (i_q == steps) begin
          held_d  = '0;
          state_d = ST_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_T_START;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign vert_idx_o = i_q;
  assign steps_o    = steps;
  assign busy_o     = (state_q != ST_IDLE);
  assign valid_o    = valid_q;
  assign last_o     = last_q;

endmodule

[src/bezier_curve_tessellator_core.sv]
// Bezier curve tessellator: de Casteljau evaluation of one 3-D curve.
// A control point item is stored while idle; after the last point each vertex
// is computed with the bit-serial divider for t and the single shared lerp
// step, which work through the n points held row by row.
// Vertices leave one per strobe, which the receiver cannot hold off.
// Reset (async, active low) empties the point store and sets step_count to 16.
module bezier_curve_tessellator_core import bct_pkg::*; #(
  parameter int unsigned MAX_CONTROL_POINTS = MAX_CONTROL_POINTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [COORD_W-1:0] point_left_i,
  input  logic signed [COORD_W-1:0] point_up_i,
  input  logic signed [COORD_W-1:0] point_forward_i,
  input  logic                      last_point_i,
  output logic                      vertex_valid_o,
  output logic signed [COORD_W-1:0] vertex_left_o,
  output logic signed [COORD_W-1:0] vertex_up_o,
  output logic signed [COORD_W-1:0] vertex_forward_o,
  output logic                      last_vertex_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [STEP_W-1:0]         cfg_data_i
);

  localparam int unsigned IDX_W =
    (MAX_CONTROL_POINTS > 1) ? $clog2(MAX_CONTROL_POINTS) : 1;

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [STEP_W-1:0] vert_idx;
  logic [STEP_W-1:0] steps;
  point_t            point_in;
  point_t            vertex;

  assign point_in    = {point_forward_i, point_up_i, point_left_i};
  assign cfg_ready_o = 1'b1;

  bct_ctrl #(
    .MAX_CONTROL_POINTS (MAX_CONTROL_POINTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .last_point_i (last_point_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .wr_addr_o    (wr_addr),
    .rd_addr_o    (rd_addr),
    .vert_idx_o   (vert_idx),
    .steps_o      (steps),
    .busy_o       (busy_o),
    .valid_o      (vertex_valid_o),
    .last_o       (last_vertex_o)
  );

  bct_datapath #(
    .MAX_CONTROL_POINTS (MAX_CONTROL_POINTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_addr_i  (wr_addr),
    .rd_addr_i  (rd_addr),
    .vert_idx_i (vert_idx),
    .steps_i    (steps),
    .point_i    (point_in),
    .status_o   (status),
    .vertex_o   (vertex)
  );

  assign vertex_left_o    = vertex[0];
  assign vertex_up_o      = vertex[1];
  assign vertex_forward_o = vertex[2];

  // A vertex strobe is never followed straight away by another
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vertex_valid_o |=> !vertex_valid_o)
    else $error("vertex strobe on consecutive cycles");

  // End-of-polyline flag only rides on a vertex
  a_last_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_vertex_o |-> vertex_valid_o)
    else $error("last_vertex without vertex strobe");

  // A last point starts evaluation
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_point_i) |=> busy_o)
    else $error("last point did not start evaluation");

  // Other points are only stored, or dropped when the store is full
  a_load_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_point_i) |=> !busy_o)
    else $error("non-last point made the block busy");

endmodule
